// File: rtl/core/rlpe_pkg.sv
// ============================================================================
// Run-length pixel encoder package
// Token kinds, queue sizing and the command that passes from the front end
// to the back end.
// ============================================================================
package rlpe_pkg;

    localparam int FIELD_W = 16;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    localparam logic [1:0] KIND_LIT = 2'd0;
    localparam logic [1:0] KIND_RUN = 2'd1;
    localparam logic [1:0] KIND_EOR = 2'd2;

    localparam logic [3:0] THR_RESET = 4'd4;
    localparam logic [3:0] THR_MIN   = 4'd2;
    localparam logic [3:0] THR_MAX   = 4'd8;

    typedef struct packed {
        logic               a_vld;
        logic               a_lit;
        logic [FIELD_W-1:0] a_val;
        logic [FIELD_W-1:0] a_cnt;
        logic               b_vld;
        logic               b_lit;
        logic [FIELD_W-1:0] b_val;
        logic [FIELD_W-1:0] b_cnt;
        logic               eor;
        logic               done;
    } t_cmd;

    function automatic logic [3:0] sat_thr(input logic [3:0] thr);
        logic [3:0] res;
        res = thr;
        if (thr < THR_MIN) res = THR_MIN;
        if (thr > THR_MAX) res = THR_MAX;
        return res;
    endfunction

endpackage

// File: rtl/core/rlpe_front.sv
// ============================================================================
// Run-length pixel encoder front end
// Tracks the open run and turns each accepted pixel that closes a run or ends
// a row into a command naming the runs it closes and whether it ends a row.
// ============================================================================
module rlpe_front #(
    parameter int PIXEL_BITS = 16,
    parameter int RUN_BITS   = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [3:0]          i_cfg_wdata,
    input  logic                i_push,
    input  logic [15:0]         i_pixel,
    input  logic                i_row_end,
    input  logic                i_image_end,
    input  logic                i_q_full,
    output logic                o_q_push,
    output rlpe_pkg::t_cmd      o_q_cmd
);

    localparam int CNT_W = (RUN_BITS >= 16) ? 16 : RUN_BITS;

    logic [PIXEL_BITS-1:0] r_val, n_val;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [3:0]            r_thr;

    logic [PIXEL_BITS-1:0] pix;
    logic [CNT_W-1:0]      cnt1;
    logic [CNT_W-1:0]      thr;
    logic                  close_a;
    logic                  b_vld;
    logic                  row;
    logic                  accept;

    always_comb begin
        pix     = i_pixel[PIXEL_BITS-1:0];
        thr     = CNT_W'(rlpe_pkg::sat_thr(r_thr));
        row     = i_row_end | i_image_end;
        accept  = i_push & ~i_q_full;
        close_a = (r_cnt != '0) && (pix != r_val);
        cnt1    = (close_a || r_cnt == '0) ? CNT_W'(1) : r_cnt + CNT_W'(1);
        b_vld   = (cnt1 == '1) || row;
        n_val   = pix;
        n_cnt   = b_vld ? '0 : cnt1;

        o_q_cmd.a_vld = close_a;
        o_q_cmd.a_lit = r_cnt < thr;
        o_q_cmd.a_val = rlpe_pkg::FIELD_W'(r_val);
        o_q_cmd.a_cnt = rlpe_pkg::FIELD_W'(r_cnt);
        o_q_cmd.b_vld = b_vld;
        o_q_cmd.b_lit = cnt1 < thr;
        o_q_cmd.b_val = rlpe_pkg::FIELD_W'(pix);
        o_q_cmd.b_cnt = rlpe_pkg::FIELD_W'(cnt1);
        o_q_cmd.eor   = row;
        o_q_cmd.done  = i_image_end;
        o_q_push      = accept & (close_a | b_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
            r_cnt <= '0;
            r_thr <= rlpe_pkg::THR_RESET;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (accept) begin
                r_val <= n_val;
                r_cnt <= n_cnt;
            end
        end
    end

endmodule

// File: rtl/core/rlpe_queue.sv
// ============================================================================
// Run-length pixel encoder command queue
// Short first-word-fall-through queue between the front and back ends.
// ============================================================================
module rlpe_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rlpe_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output rlpe_pkg::t_cmd o_head
);

    rlpe_pkg::t_cmd                  r_mem [rlpe_pkg::Q_DEPTH];
    logic [rlpe_pkg::Q_AW-1:0]       r_wr;
    logic [rlpe_pkg::Q_AW-1:0]       r_rd;
    logic [rlpe_pkg::Q_CW-1:0]       r_cnt;
    logic                            do_push;
    logic                            do_pop;

    always_comb begin
        o_full  = r_cnt == rlpe_pkg::Q_CW'(rlpe_pkg::Q_DEPTH);
        o_empty = r_cnt == '0;
        o_head  = r_mem[r_rd];
        do_push = i_push & ~o_full;
        do_pop  = i_pop & ~o_empty;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/rlpe_back.sv
// ============================================================================
// Run-length pixel encoder back end
// Expands each command into literal, run and end-of-row tokens in an output
// register, one a cycle while that register is free or being popped.
// ============================================================================
module rlpe_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rlpe_pkg::t_cmd i_head,
    input  logic           i_q_empty,
    output logic           o_q_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [1:0]     o_kind,
    output logic [15:0]    o_value,
    output logic [15:0]    o_run_length,
    output logic           o_image_done,
    output logic           o_last
);

    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_E
    } t_phase;

    t_phase        r_phase, n_phase, eff;
    logic [2:0]    r_lcnt, n_lcnt;
    logic          r_out_vld, n_out_vld;
    logic [1:0]    r_kind, n_kind;
    logic [15:0]   r_value, n_value;
    logic [15:0]   r_len, n_len;
    logic          r_done, n_done;
    logic          r_last, n_last;

    logic          lit;
    logic [15:0]   val;
    logic [15:0]   cnt;
    logic          ph_done;
    logic          adv;

    always_comb begin
        if (r_phase == PH_A && i_head.a_vld) begin
            eff = PH_A;
        end else if (r_phase != PH_E && i_head.b_vld) begin
            eff = PH_B;
        end else begin
            eff = PH_E;
        end

        lit = (eff == PH_A) ? i_head.a_lit : i_head.b_lit;
        val = (eff == PH_A) ? i_head.a_val : i_head.b_val;
        cnt = (eff == PH_A) ? i_head.a_cnt : i_head.b_cnt;

        case (eff)
            PH_A, PH_B: begin
                ph_done = !lit || ((r_lcnt + 3'd1) == cnt[2:0]);
                n_kind  = lit ? rlpe_pkg::KIND_LIT : rlpe_pkg::KIND_RUN;
                n_value = val;
                n_len   = lit ? 16'd1 : cnt;
                n_done  = 1'b0;
            end
            default: begin
                ph_done = 1'b1;
                n_kind  = rlpe_pkg::KIND_EOR;
                n_value = '0;
                n_len   = '0;
                n_done  = i_head.done;
            end
        endcase

        case (eff)
            PH_A:    n_last = ph_done && !i_head.b_vld && !i_head.eor;
            PH_B:    n_last = ph_done && !i_head.eor;
            default: n_last = 1'b1;
        endcase

        adv     = !i_q_empty && (!r_out_vld || i_pop);
        o_q_pop = adv && n_last;

        n_out_vld = r_out_vld;
        n_phase   = r_phase;
        n_lcnt    = r_lcnt;
        if (adv) begin
            n_out_vld = 1'b1;
            if (n_last) begin
                n_phase = PH_A;
                n_lcnt  = '0;
            end else if (ph_done) begin
                n_phase = (eff == PH_A) ? PH_B : PH_E;
                n_lcnt  = '0;
            end else begin
                n_lcnt = r_lcnt + 3'd1;
            end
        end else if (i_pop) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_A;
            r_lcnt    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_lcnt    <= n_lcnt;
            r_out_vld <= n_out_vld;
        end
        if (adv) begin
            r_kind  <= n_kind;
            r_value <= n_value;
            r_len   <= n_len;
            r_done  <= n_done;
            r_last  <= n_last;
        end
    end

    assign o_empty      = !r_out_vld;
    assign o_kind       = r_kind;
    assign o_value      = r_value;
    assign o_run_length = r_len;
    assign o_image_done = r_done;
    assign o_last       = r_last;

endmodule

// File: rtl/core/run_length_pixel_encoder_unit.sv
// ============================================================================
// Run-length pixel encoder
// Encodes a row-ordered gray pixel stream into literal, run and end-of-row
// tokens.
// ============================================================================
// One pixel is taken per cycle while full is low, and one token leaves per
// cycle while pop is held and empty is low. A pixel yields up to nine tokens
// (up to eight literals and an end-of-row token); the single-token-a-cycle
// expansion in the back end sets the output rate, and a four-entry command
// queue absorbs bursts before full rises. A token passes through the command
// queue and the back-end output register on its way to the outputs.
module run_length_pixel_encoder_unit #(
    parameter int PIXEL_BITS = 16,
    parameter int RUN_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_pixel,
    input  logic        i_row_end,
    input  logic        i_image_end,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [15:0] o_value,
    output logic [15:0] o_run_length,
    output logic        o_image_done,
    output logic        o_last
);

    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;
    rlpe_pkg::t_cmd q_cmd;
    rlpe_pkg::t_cmd q_head;

    assign full = q_full;

    rlpe_front #(
        .PIXEL_BITS (PIXEL_BITS),
        .RUN_BITS   (RUN_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_pixel     (i_pixel),
        .i_row_end   (i_row_end),
        .i_image_end (i_image_end),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_cmd)
    );

    rlpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    rlpe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_kind       (o_kind),
        .o_value      (o_value),
        .o_run_length (o_run_length),
        .o_image_done (o_image_done),
        .o_last       (o_last)
    );

endmodule

// File: rtl/core/rlpe_checker.sv
// ============================================================================
// Run-length pixel encoder checker
// Port-level checks on the token stream, bound to the top level.
// ============================================================================
module rlpe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_kind,
    input logic [15:0] o_value,
    input logic [15:0] o_run_length,
    input logic        o_image_done,
    input logic        o_last
);

    a_hold_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_kind) && $stable(o_value)
            && $stable(o_run_length) && $stable(o_image_done) && $stable(o_last)))
        else $error("stalled beat changed");

    a_eor_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == rlpe_pkg::KIND_EOR) |->
            (o_value == '0 && o_run_length == '0 && o_last))
        else $error("malformed end-of-row beat");

    a_lit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == rlpe_pkg::KIND_LIT) |-> (o_run_length == 16'd1 && !o_image_done))
        else $error("malformed literal beat");

    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == rlpe_pkg::KIND_RUN) |-> (o_run_length >= 16'd2 && !o_image_done))
        else $error("malformed run beat");

    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_kind == rlpe_pkg::KIND_LIT || o_kind == rlpe_pkg::KIND_RUN
            || o_kind == rlpe_pkg::KIND_EOR))
        else $error("unknown beat kind");

endmodule

bind run_length_pixel_encoder_unit rlpe_checker u_rlpe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .empty        (empty),
    .pop          (pop),
    .o_kind       (o_kind),
    .o_value      (o_value),
    .o_run_length (o_run_length),
    .o_image_done (o_image_done),
    .o_last       (o_last)
);

// File: tb/run_length_pixel_encoder_unit_test.sv
`timescale 1ns / 100ps
// ============================================================================
// Run-length pixel encoder testbench
// Pushes a directed table of pixel rows and random rows under several
// thresholds. Every token that is popped is compared, field by field, with the
// tokens listed in the table or with the output of a cycle-free encoder model
// kept here, while both queue sides stall at random.
// ============================================================================
module run_length_pixel_encoder_unit_test;

    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam logic [15:0] RUN_CAP     = 16'hFFFF;
    localparam int          N_PHASES    = 9;
    localparam logic [3:0]  THR_PLAN [N_PHASES] = '{4'd0, 4'd15, 4'd2, 4'd8, 4'd1,
                                                    4'd9, 4'd3, 4'd4, 4'd6};

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic [15:0] run_length;
        logic        image_done;
        logic        last;
    } t_token;

    typedef struct packed {
        logic [15:0] pixel;
        logic        row_end;
        logic        image_end;
        logic        fixed;
        t_token      tok0;
        t_token      tok1;
    } t_pixel_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [3:0]  i_cfg_wdata = 4'd0;
    logic        push        = 1'b0;
    logic        full;
    logic [15:0] i_pixel     = 16'd0;
    logic        i_row_end   = 1'b0;
    logic        i_image_end = 1'b0;
    logic        empty;
    logic        pop         = 1'b0;
    logic [1:0]  o_kind;
    logic [15:0] o_value;
    logic [15:0] o_run_length;
    logic        o_image_done;
    logic        o_last;

    logic [15:0] enc_value;
    logic [15:0] enc_count;
    logic [3:0]  enc_thr;

    t_token      step_tokens [$];
    t_token      tokens_due  [$];
    t_pixel_row  directed    [$];
    t_token      want;

    bit          calm       = 1'b0;
    int          pop_hold   = 0;
    int          n_cycles   = 0;
    int          n_errors   = 0;
    int          n_pixels   = 0;
    int          n_tokens   = 0;
    int          n_settings = 0;

    run_length_pixel_encoder_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .push         (push),
        .full         (full),
        .i_pixel      (i_pixel),
        .i_row_end    (i_row_end),
        .i_image_end  (i_image_end),
        .empty        (empty),
        .pop          (pop),
        .o_kind       (o_kind),
        .o_value      (o_value),
        .o_run_length (o_run_length),
        .o_image_done (o_image_done),
        .o_last       (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_token tok(input logic [1:0] kind, input logic [15:0] value,
                                   input logic [15:0] len, input logic done,
                                   input logic last);
        t_token t;
        t.kind       = kind;
        t.value      = value;
        t.run_length = len;
        t.image_done = done;
        t.last       = last;
        return t;
    endfunction

    function automatic t_pixel_row mk_row(input logic [15:0] pix, input logic re,
                                          input logic ie, input logic fixed,
                                          input t_token t0, input t_token t1);
        t_pixel_row r;
        r.pixel     = pix;
        r.row_end   = re;
        r.image_end = ie;
        r.fixed     = fixed;
        r.tok0      = t0;
        r.tok1      = t1;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic close_run();
        logic [3:0] thr;
        thr = enc_thr;
        if (thr < rlpe_pkg::THR_MIN) thr = rlpe_pkg::THR_MIN;
        if (thr > rlpe_pkg::THR_MAX) thr = rlpe_pkg::THR_MAX;
        if (enc_count == 16'd0) return;
        if (enc_count < {12'd0, thr}) begin
            repeat (enc_count) step_tokens.push_back(tok(rlpe_pkg::KIND_LIT, enc_value,
                                                         16'd1, 1'b0, 1'b0));
        end else begin
            step_tokens.push_back(tok(rlpe_pkg::KIND_RUN, enc_value, enc_count, 1'b0, 1'b0));
        end
        enc_count = 16'd0;
    endtask

    task automatic encode_pixel(input logic [15:0] pix, input logic re, input logic ie);
        t_token t;
        step_tokens.delete();
        if (enc_count != 16'd0 && pix != enc_value) close_run();
        if (enc_count == 16'd0) begin
            enc_value = pix;
            enc_count = 16'd1;
        end else begin
            enc_count = enc_count + 16'd1;
        end
        if (enc_count == RUN_CAP) close_run();
        if (re || ie) begin
            close_run();
            step_tokens.push_back(tok(rlpe_pkg::KIND_EOR, 16'd0, 16'd0, ie, 1'b0));
        end
        if (step_tokens.size() > 0) begin
            t = step_tokens.pop_back();
            t.last = 1'b1;
            step_tokens.push_back(t);
        end
    endtask

    task automatic put_pixel(input t_pixel_row r);
        int gap;
        bit taken;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_pixel     <= r.pixel;
        i_row_end   <= r.row_end;
        i_image_end <= r.image_end;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !full;
            @(posedge i_clk);
        end
        encode_pixel(r.pixel, r.row_end, r.image_end);
        if (r.fixed) begin
            tokens_due.push_back(r.tok0);
            tokens_due.push_back(r.tok1);
        end else begin
            foreach (step_tokens[k]) tokens_due.push_back(step_tokens[k]);
        end
        n_pixels++;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_threshold(input logic [3:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        enc_thr = v;
        n_settings++;
    endtask

    task automatic random_pixels(input int count);
        int row_left;
        int run_left;
        logic [15:0] pix;
        logic re;
        logic ie;
        row_left = 0;
        run_left = 0;
        pix      = 16'd0;
        for (int n = 0; n < count; n++) begin
            if (row_left == 0) begin
                row_left = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                        : $urandom_range(1, 24);
            end
            if (run_left == 0) begin
                run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 20)
                                                        : $urandom_range(1, 10);
                case ($urandom_range(0, 7))
                    0: pix = 16'h0000;
                    1: pix = 16'hFFFF;
                    2, 3: pix = 16'($urandom_range(0, 3));
                    default: pix = 16'($urandom);
                endcase
            end
            re = (row_left == 1);
            ie = re ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 39) == 0);
            // break the row shape now and then
            if ($urandom_range(0, 29) == 0) begin
                pix = 16'($urandom);
                re  = 1'($urandom_range(0, 1));
            end
            put_pixel(mk_row(pix, re, ie, 1'b0, '0, '0));
            row_left = (re || ie) ? 0 : row_left - 1;
            run_left = run_left - 1;
        end
    endtask

    always @(posedge i_clk) begin
        if (pop_hold > 0) begin
            pop <= 1'b0;
            pop_hold = pop_hold - 1;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            pop <= 1'b0;
            pop_hold = pick_gap();
        end else begin
            pop <= 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (tokens_due.size() == 0) begin
                $error("unexpected token: kind %0d value %h run_length %0d",
                       o_kind, o_value, o_run_length);
                n_errors++;
            end else begin
                want = tokens_due.pop_front();
                n_tokens++;
                if (o_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_kind);
                    n_errors++;
                end
                if (o_value !== want.value) begin
                    $error("value: expected %h, got %h", want.value, o_value);
                    n_errors++;
                end
                if (o_run_length !== want.run_length) begin
                    $error("run_length: expected %0d, got %0d", want.run_length, o_run_length);
                    n_errors++;
                end
                if (o_image_done !== want.image_done) begin
                    $error("image_done: expected %0d, got %0d", want.image_done, o_image_done);
                    n_errors++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        // single pixels at the extremes, then runs just at and below the threshold
        directed.push_back(mk_row(16'h0000, 1'b1, 1'b0, 1'b1,
                                  tok(rlpe_pkg::KIND_LIT, 16'h0000, 16'd1, 1'b0, 1'b0),
                                  tok(rlpe_pkg::KIND_EOR, 16'h0000, 16'd0, 1'b0, 1'b1)));
        directed.push_back(mk_row(16'hFFFF, 1'b1, 1'b0, 1'b1,
                                  tok(rlpe_pkg::KIND_LIT, 16'hFFFF, 16'd1, 1'b0, 1'b0),
                                  tok(rlpe_pkg::KIND_EOR, 16'h0000, 16'd0, 1'b0, 1'b1)));
        repeat (3) directed.push_back(mk_row(16'h0007, 1'b0, 1'b0, 1'b0, '0, '0));
        directed.push_back(mk_row(16'h0007, 1'b1, 1'b0, 1'b1,
                                  tok(rlpe_pkg::KIND_RUN, 16'h0007, 16'd4, 1'b0, 1'b0),
                                  tok(rlpe_pkg::KIND_EOR, 16'h0000, 16'd0, 1'b0, 1'b1)));
        repeat (3) directed.push_back(mk_row(16'h0005, 1'b0, 1'b0, 1'b0, '0, '0));
        directed.push_back(mk_row(16'h0009, 1'b1, 1'b0, 1'b0, '0, '0));
        repeat (5) directed.push_back(mk_row(16'h00A5, 1'b0, 1'b0, 1'b0, '0, '0));
        directed.push_back(mk_row(16'h0002, 1'b0, 1'b0, 1'b0, '0, '0));
        directed.push_back(mk_row(16'h0002, 1'b0, 1'b1, 1'b0, '0, '0));
        directed.push_back(mk_row(16'h8000, 1'b1, 1'b1, 1'b1,
                                  tok(rlpe_pkg::KIND_LIT, 16'h8000, 16'd1, 1'b0, 1'b0),
                                  tok(rlpe_pkg::KIND_EOR, 16'h0000, 16'd0, 1'b1, 1'b1)));
        directed.push_back(mk_row(16'hAAAA, 1'b0, 1'b0, 1'b0, '0, '0));
        directed.push_back(mk_row(16'h5555, 1'b0, 1'b0, 1'b0, '0, '0));
        directed.push_back(mk_row(16'hAAAA, 1'b1, 1'b0, 1'b0, '0, '0));

        enc_value = 16'd0;
        enc_count = 16'd0;
        enc_thr   = rlpe_pkg::THR_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) put_pixel(directed[k]);

        for (int p = 0; p < N_PHASES; p++) begin
            set_threshold(THR_PLAN[p]);
            calm = (p % 3 == 1);
            random_pixels(30);
            calm = 1'b0;
        end

        drain();
        repeat (12) @(posedge i_clk);
        $display("covered %0d pixels and %0d tokens under %0d threshold settings,",
                 n_pixels, n_tokens, n_settings + 1);
        $display("with random stalls on both sides; %0d mismatches", n_errors);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: run_length_pixel_encoder_unit.f
rtl/core/rlpe_pkg.sv
rtl/core/rlpe_front.sv
rtl/core/rlpe_queue.sv
rtl/core/rlpe_back.sv
rtl/core/run_length_pixel_encoder_unit.sv
rtl/core/rlpe_checker.sv
tb/run_length_pixel_encoder_unit_test.sv
